@@ rtl/two_class_priority_queue_cancel_unit_macros.svh @@
// assertion macros for the two-class priority queue checker
`ifndef TWO_CLASS_PRIORITY_QUEUE_CANCEL_UNIT_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CANCEL_UNIT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define TCQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds during reset
`define TCQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tcq_pkg.sv @@
// types and constants shared by the two-class priority queue
package tcq_pkg;

    localparam int DEPTH       = 16;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int TICKET_W    = 16;
    localparam int TAG_W       = 16;
    localparam int ENTRY_W     = TICKET_W + TAG_W;
    localparam int OCC_W       = 5;
    localparam int NORMAL_W    = 7;

    localparam logic [NORMAL_W-1:0] NORMAL_LAST = NORMAL_W'(99);
    localparam logic [TICKET_W-1:0] URGENT_BASE = TICKET_W'(100);
    localparam logic [TICKET_W-1:0] URGENT_LAST = '1;

    typedef enum logic [1:0] {
        OP_ADD_NORMAL = 2'd0,
        OP_ADD_URGENT = 2'd1,
        OP_SERVE      = 2'd2,
        OP_CANCEL     = 2'd3
    } tcq_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } tcq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPEN,
        S_SCAN,
        S_SERVE_RD,
        S_HEAD,
        S_DROP,
        S_DONE
    } tcq_state_t;

endpackage

@@ rtl/tcq_in_if.sv @@
// request channel of the two-class priority queue
interface tcq_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   operation;
    logic [tcq_pkg::TAG_W-1:0]    client_tag;
    logic [tcq_pkg::TICKET_W-1:0] cancel_ticket;

    modport source (output valid, operation, client_tag, cancel_ticket, input ready);
    modport sink   (input valid, operation, client_tag, cancel_ticket, output ready);
endinterface

@@ rtl/tcq_out_if.sv @@
// response channel of the two-class priority queue
interface tcq_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [tcq_pkg::TICKET_W-1:0] ticket_out;
    logic [tcq_pkg::TAG_W-1:0]    tag_out;
    logic                         urgent_waiting;
    logic [tcq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, ticket_out, tag_out, urgent_waiting, occupancy,
                    input ready);
    modport sink   (input valid, status, ticket_out, tag_out, urgent_waiting, occupancy,
                    output ready);
endinterface

@@ rtl/two_class_priority_queue_cancel_unit.sv @@
// two-class priority queue with cancel by ticket, one shared ram port sequenced per request
//
// usage
//   req carries one request: operation (add normal, add urgent, serve head, cancel by
//   ticket), client_tag for adds and cancel_ticket for cancels. rsp returns exactly one
//   response per request: status, ticket_out, tag_out, urgent_waiting and occupancy.
//   the queue lives in one ram in service order, urgent entries first; every insert,
//   serve or cancel moves entries one slot a cycle through that ram's single read and
//   write port, so the ram port is what sets the time per request.
//   req.ready is high only between requests; one request is worked on at a time.
// reset
//   asynchronous, active low: the queue is empty, the normal ticket counter restarts at
//   1 and the urgent one at 100. the ram contents are not cleared; only slots below the
//   fill count are ever read.
// stalls
//   the response sits in an output register; while rsp.ready is low the next request
//   may still be accepted and worked on, and its response waits until the slot frees.
module two_class_priority_queue_cancel_unit (
    input  logic       clk,
    input  logic       rst_n,
    tcq_in_if.sink     req,
    tcq_out_if.source  rsp
);

    localparam int AW = tcq_pkg::ADDR_W;
    localparam int CW = tcq_pkg::CNT_W;
    localparam int TW = tcq_pkg::TICKET_W;
    localparam int GW = tcq_pkg::TAG_W;
    localparam int EW = tcq_pkg::ENTRY_W;

    // control state
    tcq_pkg::tcq_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] urg_cnt_reg, urg_cnt_next;
    logic [tcq_pkg::NORMAL_W-1:0] norm_ctr_reg, norm_ctr_next;
    logic [TW-1:0] urg_ctr_reg, urg_ctr_next;
    logic wr_pend_reg, wr_pend_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic out_valid_reg, out_valid_next;

    // working registers of the sequencer
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic urg_op_reg, urg_op_next;
    logic [TW-1:0] arg_reg, arg_next;
    tcq_pkg::tcq_status_t res_status_reg, res_status_next;
    logic [TW-1:0] res_ticket_reg, res_ticket_next;
    logic [GW-1:0] res_tag_reg, res_tag_next;

    // response register
    tcq_pkg::tcq_status_t out_status_reg, out_status_next;
    logic [TW-1:0] out_ticket_reg, out_ticket_next;
    logic [GW-1:0] out_tag_reg, out_tag_next;
    logic out_urg_reg, out_urg_next;
    logic [tcq_pkg::OCC_W-1:0] out_occ_reg, out_occ_next;

    // ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    logic [CW-1:0] rd_m1;
    logic [TW-1:0] rd_ticket;
    logic [GW-1:0] rd_tag;

    assign rd_m1     = rd_ptr_reg - CW'(1);
    assign rd_ticket = ram_rdata[EW-1:GW];
    assign rd_tag    = ram_rdata[GW-1:0];

    tcq_ram #(
        .WIDTH (EW),
        .DEPTH (tcq_pkg::DEPTH)
    ) u_tcq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready          = (state_reg == tcq_pkg::S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.ticket_out     = out_ticket_reg;
    assign rsp.tag_out        = out_tag_reg;
    assign rsp.urgent_waiting = out_urg_reg;
    assign rsp.occupancy      = out_occ_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        urg_cnt_next    = urg_cnt_reg;
        norm_ctr_next   = norm_ctr_reg;
        urg_ctr_next    = urg_ctr_reg;
        wr_pend_next    = 1'b0;
        cmp_vld_next    = 1'b0;
        out_valid_next  = out_valid_reg;
        rd_ptr_next     = rd_ptr_reg;
        pos_next        = pos_reg;
        wr_addr_next    = wr_addr_reg;
        urg_op_next     = urg_op_reg;
        arg_next        = arg_reg;
        res_status_next = res_status_reg;
        res_ticket_next = res_ticket_reg;
        res_tag_next    = res_tag_reg;
        out_status_next = out_status_reg;
        out_ticket_next = out_ticket_reg;
        out_tag_next    = out_tag_reg;
        out_urg_next    = out_urg_reg;
        out_occ_next    = out_occ_reg;
        ram_raddr       = '0;

        // a slot move read last cycle is written back now
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tcq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    res_status_next = tcq_pkg::ST_OK;
                    res_ticket_next = '0;
                    res_tag_next    = '0;
                    case (tcq_pkg::tcq_op_t'(req.operation))
                        tcq_pkg::OP_ADD_NORMAL, tcq_pkg::OP_ADD_URGENT:
                        begin
                            if (count_reg == CW'(tcq_pkg::DEPTH))
                            begin
                                res_status_next = tcq_pkg::ST_FULL;
                                state_next      = tcq_pkg::S_DONE;
                            end
                            else
                            begin
                                arg_next    = req.client_tag;
                                rd_ptr_next = count_reg;
                                state_next  = tcq_pkg::S_OPEN;
                                if (req.operation == tcq_pkg::OP_ADD_NORMAL)
                                begin
                                    norm_ctr_next = (norm_ctr_reg >= tcq_pkg::NORMAL_LAST)
                                                  ? tcq_pkg::NORMAL_W'(1)
                                                  : norm_ctr_reg + tcq_pkg::NORMAL_W'(1);
                                    res_ticket_next = TW'(norm_ctr_next);
                                    pos_next        = count_reg;
                                    urg_op_next     = 1'b0;
                                end
                                else
                                begin
                                    res_ticket_next = urg_ctr_reg;
                                    urg_ctr_next    = (urg_ctr_reg == tcq_pkg::URGENT_LAST)
                                                    ? tcq_pkg::URGENT_BASE
                                                    : urg_ctr_reg + TW'(1);
                                    // urgent entries go in behind the last urgent one
                                    pos_next        = urg_cnt_reg;
                                    urg_op_next     = 1'b1;
                                end
                            end
                        end
                        tcq_pkg::OP_SERVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = tcq_pkg::ST_EMPTY;
                                state_next      = tcq_pkg::S_DONE;
                            end
                            else
                            begin
                                urg_op_next = (urg_cnt_reg != '0);
                                state_next  = tcq_pkg::S_SERVE_RD;
                            end
                        end
                        tcq_pkg::OP_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = tcq_pkg::ST_EMPTY;
                                state_next      = tcq_pkg::S_DONE;
                            end
                            else
                            begin
                                arg_next    = req.cancel_ticket;
                                rd_ptr_next = '0;
                                state_next  = tcq_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = tcq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // shift the tail up one slot, top first, then drop the new entry in
            tcq_pkg::S_OPEN:
            begin
                if (rd_ptr_reg > pos_reg)
                begin
                    ram_raddr    = rd_m1[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = rd_ptr_reg[AW-1:0];
                    rd_ptr_next  = rd_m1;
                end
                else if (!wr_pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = {res_ticket_reg, arg_reg};
                    count_next = count_reg + CW'(1);
                    if (urg_op_reg)
                    begin
                        urg_cnt_next = urg_cnt_reg + CW'(1);
                    end
                    state_next = tcq_pkg::S_DONE;
                end
            end

            // read one entry a cycle and compare it in the cycle after its read; the first match wins
            tcq_pkg::S_SCAN:
            begin
                if (cmp_vld_reg && (rd_ticket == arg_reg))
                begin
                    // match sits at rd_ptr - 1, so rd_ptr is already the first slot to pull down
                    urg_op_next = (rd_ptr_reg <= urg_cnt_reg);
                    state_next  = tcq_pkg::S_DROP;
                end
                else if (rd_ptr_reg < count_reg)
                begin
                    ram_raddr    = rd_ptr_reg[AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                end
                else
                begin
                    res_status_next = tcq_pkg::ST_NOT_FOUND;
                    state_next      = tcq_pkg::S_DONE;
                end
            end

            tcq_pkg::S_SERVE_RD:
            begin
                ram_raddr  = '0;
                state_next = tcq_pkg::S_HEAD;
            end

            tcq_pkg::S_HEAD:
            begin
                res_ticket_next = rd_ticket;
                res_tag_next    = rd_tag;
                rd_ptr_next     = CW'(1);
                state_next      = tcq_pkg::S_DROP;
            end

            // pull the entries above the gap down one slot, bottom first
            tcq_pkg::S_DROP:
            begin
                if (rd_ptr_reg < count_reg)
                begin
                    ram_raddr    = rd_ptr_reg[AW-1:0];
                    wr_pend_next = 1'b1;
                    wr_addr_next = rd_m1[AW-1:0];
                    rd_ptr_next  = rd_ptr_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (urg_op_reg)
                    begin
                        urg_cnt_next = urg_cnt_reg - CW'(1);
                    end
                    state_next = tcq_pkg::S_DONE;
                end
            end

            // hand the response over once the output register is free
            tcq_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_ticket_next = res_ticket_reg;
                    out_tag_next    = res_tag_reg;
                    out_urg_next    = (urg_cnt_reg != '0);
                    out_occ_next    = tcq_pkg::OCC_W'(count_reg);
                    state_next      = tcq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tcq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcq_pkg::S_IDLE;
            count_reg     <= '0;
            urg_cnt_reg   <= '0;
            norm_ctr_reg  <= '0;
            urg_ctr_reg   <= tcq_pkg::URGENT_BASE;
            wr_pend_reg   <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            urg_cnt_reg   <= urg_cnt_next;
            norm_ctr_reg  <= norm_ctr_next;
            urg_ctr_reg   <= urg_ctr_next;
            wr_pend_reg   <= wr_pend_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        pos_reg        <= pos_next;
        wr_addr_reg    <= wr_addr_next;
        urg_op_reg     <= urg_op_next;
        arg_reg        <= arg_next;
        res_status_reg <= res_status_next;
        res_ticket_reg <= res_ticket_next;
        res_tag_reg    <= res_tag_next;
        out_status_reg <= out_status_next;
        out_ticket_reg <= out_ticket_next;
        out_tag_reg    <= out_tag_next;
        out_urg_reg    <= out_urg_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

@@ rtl/tcq_ram.sv @@
// generic single-write, single-read ram with registered read data
module tcq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tcq_checker.sv @@
// port-level checks for the two-class priority queue, bound to the top level
`include "two_class_priority_queue_cancel_unit_macros.svh"

module tcq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic [1:0]                   rsp_status,
    input logic [tcq_pkg::TICKET_W-1:0] rsp_ticket_out,
    input logic [tcq_pkg::TAG_W-1:0]    rsp_tag_out,
    input logic                         rsp_urgent_waiting,
    input logic [tcq_pkg::OCC_W-1:0]    rsp_occupancy
);

    // a taken request keeps the block busy for at least the next cycle
    `TCQ_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "ready right after a request")

    // refused or missed requests carry no ticket and no tag
    `TCQ_ASSERT(a_fail_zero, rsp_valid && (rsp_status != tcq_pkg::ST_OK) |-> (rsp_ticket_out == '0) && (rsp_tag_out == '0), "nonzero payload on failed request")

    // an empty report leaves nothing queued
    `TCQ_ASSERT(a_empty_state, rsp_valid && (rsp_status == tcq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0) && !rsp_urgent_waiting, "empty status with entries queued")

    // no response is offered on the edge after reset is seen
    `TCQ_ASSERT_RST(a_reset_quiet, !rst_n |=> !rsp_valid, "response valid after reset")

endmodule

bind two_class_priority_queue_cancel_unit tcq_checker u_tcq_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_status         (rsp.status),
    .rsp_ticket_out     (rsp.ticket_out),
    .rsp_tag_out        (rsp.tag_out),
    .rsp_urgent_waiting (rsp.urgent_waiting),
    .rsp_occupancy      (rsp.occupancy)
);

@@ verif/testbench.sv @@
// self-checking testbench for the two-class priority queue with cancel by ticket
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcq_pkg::*;

    // one queued entry, held in service order by the predictor
    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [TAG_W-1:0]    tag;
    } slot_t;

    // one response as the block should return it
    typedef struct packed {
        tcq_status_t         status;
        logic [TICKET_W-1:0] ticket;
        logic [TAG_W-1:0]    tag;
        logic                urgent;
        logic [OCC_W-1:0]    occupancy;
    } reply_t;

    // one row of the directed table; pinned rows carry a hand-written reply
    typedef struct packed {
        tcq_op_t             op;
        logic [TAG_W-1:0]    tag;
        logic [TICKET_W-1:0] ticket;
        logic [7:0]          reps;
        logic                pinned;
        reply_t              reply;
    } probe_t;

    localparam int NUM_PROBES = 14;
    localparam int MAX_SHOWN  = 10;

    // directed part: empty queue, extremes of the fields, a full queue, every operation
    localparam probe_t PROBE_TABLE [NUM_PROBES] = '{
        // serve and cancel straight after reset both see an empty queue
        '{OP_SERVE,      16'h0000, 16'h0000, 8'd1, 1'b1, '{ST_EMPTY, 16'd0, 16'd0, 1'b0, 5'd0}},
        '{OP_CANCEL,     16'h0000, 16'h0000, 8'd1, 1'b1, '{ST_EMPTY, 16'd0, 16'd0, 1'b0, 5'd0}},
        // first tickets of each class
        '{OP_ADD_NORMAL, 16'h0000, 16'hffff, 8'd1, 1'b1, '{ST_OK, 16'd1, 16'd0, 1'b0, 5'd1}},
        '{OP_ADD_URGENT, 16'hffff, 16'h0000, 8'd1, 1'b1, '{ST_OK, 16'd100, 16'd0, 1'b1, 5'd2}},
        // ticket that was never handed out
        '{OP_CANCEL,     16'h0000, 16'hffff, 8'd1, 1'b1,
          '{ST_NOT_FOUND, 16'd0, 16'd0, 1'b1, 5'd2}},
        // fill to the brim from both classes
        '{OP_ADD_NORMAL, 16'ha5a5, 16'h0000, 8'd7, 1'b0, '0},
        '{OP_ADD_URGENT, 16'h5a5a, 16'hffff, 8'd7, 1'b0, '0},
        // adds to a full queue are refused and leave the counters alone
        '{OP_ADD_NORMAL, 16'hffff, 16'hffff, 8'd1, 1'b1, '{ST_FULL, 16'd0, 16'd0, 1'b1, 5'd16}},
        '{OP_ADD_URGENT, 16'h0000, 16'h0000, 8'd1, 1'b1, '{ST_FULL, 16'd0, 16'd0, 1'b1, 5'd16}},
        // cancel from the middle of the urgent run and from the tail
        '{OP_CANCEL,     16'h1234, 16'd103,  8'd1, 1'b0, '0},
        '{OP_CANCEL,     16'h0000, 16'd8,    8'd1, 1'b0, '0},
        // urgent insert lands behind the other urgent entries, ahead of the normal ones
        '{OP_ADD_URGENT, 16'h8001, 16'h0000, 8'd1, 1'b0, '0},
        '{OP_SERVE,      16'h0000, 16'h0000, 8'd1, 1'b0, '0},
        // first normal entry, right behind the urgent run
        '{OP_CANCEL,     16'h0000, 16'd1,    8'd1, 1'b0, '0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcq_in_if  req_ch ();
    tcq_out_if rsp_ch ();

    two_class_priority_queue_cancel_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state: the queue in service order, urgent entries first
    slot_t               line_q [$];
    int                  urgent_held;
    logic [NORMAL_W-1:0] normal_last;
    logic [TICKET_W-1:0] urgent_next;

    // replies owed by the block, oldest first
    reply_t              replies_due [$];
    int unsigned         failures;

    // random idling on the request side and stalling on the response side
    bit                  req_gaps_on;
    bit                  rsp_stalls_on;

    // work out the reply to one request and move the predictor state on
    function automatic reply_t predict_queue_step(tcq_op_t op, logic [TAG_W-1:0] tag,
                                                  logic [TICKET_W-1:0] want);
        reply_t r;
        slot_t  s;
        int     hit;
        r        = '0;
        r.status = ST_OK;
        s.tag    = tag;
        s.ticket = '0;
        hit      = -1;
        case (op)
            OP_ADD_NORMAL, OP_ADD_URGENT:
            begin
                if (line_q.size() >= DEPTH)
                begin
                    // refused: no ticket is used up
                    r.status = ST_FULL;
                end
                else if (op == OP_ADD_NORMAL)
                begin
                    // normal tickets run 1 to 99 then start again at 1
                    normal_last = (normal_last >= NORMAL_LAST) ? NORMAL_W'(1) : normal_last + 1'b1;
                    r.ticket    = TICKET_W'(normal_last);
                    s.ticket    = r.ticket;
                    line_q.push_back(s);
                end
                else
                begin
                    // urgent tickets run 100 to the top of the field then back to 100
                    r.ticket    = urgent_next;
                    urgent_next = (urgent_next == URGENT_LAST) ? URGENT_BASE : urgent_next + 1'b1;
                    s.ticket    = r.ticket;
                    line_q.insert(urgent_held, s);
                    urgent_held++;
                end
            end
            OP_SERVE:
            begin
                if (line_q.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    s        = line_q.pop_front();
                    r.ticket = s.ticket;
                    r.tag    = s.tag;
                    if (urgent_held > 0)
                        urgent_held--;
                end
            end
            default:
            begin
                if (line_q.size() == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    // a ticket queued twice loses the copy nearest the head
                    for (int i = 0; i < line_q.size() && hit < 0; i++)
                        if (line_q[i].ticket == want)
                            hit = i;
                    if (hit < 0)
                    begin
                        r.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        line_q.delete(hit);
                        if (hit < urgent_held)
                            urgent_held--;
                    end
                end
            end
        endcase
        r.urgent    = (urgent_held != 0);
        r.occupancy = OCC_W'(line_q.size());
        return r;
    endfunction

    // hand one request over, with a random gap first, and book its reply
    task automatic send_request(input tcq_op_t op, input logic [TAG_W-1:0] tag,
                                input logic [TICKET_W-1:0] want, output reply_t forecast);
        while (req_gaps_on && $urandom_range(0, 99) < 28)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.operation     <= op;
        req_ch.client_tag    <= tag;
        req_ch.cancel_ticket <= want;
        do
            @(posedge clk);
        while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        forecast = predict_queue_step(op, tag, want);
        replies_due.push_back(forecast);
    endtask

    // hold the request side off until every reply owed has come back
    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // stimulus: directed table, random mix, normal ticket lap
    initial
    begin
        tcq_op_t             op;
        logic [TAG_W-1:0]    tag;
        logic [TICKET_W-1:0] want;
        logic [TICKET_W-1:0] held;
        logic [TICKET_W-1:0] last_served;
        reply_t              forecast;
        int                  fill_goal;
        int                  pick;
        bit                  adding;

        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_ADD_NORMAL;
        req_ch.client_tag    = '0;
        req_ch.cancel_ticket = '0;
        line_q.delete();
        urgent_held   = 0;
        normal_last   = '0;
        urgent_next   = URGENT_BASE;
        failures      = 0;
        last_served   = '0;
        fill_goal     = 0;
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; pinned rows override the predictor with the written reply
        foreach (PROBE_TABLE[i])
            for (int n = 0; n < PROBE_TABLE[i].reps; n++)
            begin
                send_request(PROBE_TABLE[i].op, PROBE_TABLE[i].tag, PROBE_TABLE[i].ticket,
                             forecast);
                if (PROBE_TABLE[i].pinned)
                    replies_due[replies_due.size() - 1] = PROBE_TABLE[i].reply;
            end
        wait_for_replies();

        // random mix, steered towards a fill level that changes every forty requests
        // so that both the empty and the full queue come round often
        for (int k = 0; k < 320; k++)
        begin
            if (k % 40 == 0)
                fill_goal = $urandom_range(0, 3) * 6;
            // long stretch with no idling on either side
            req_gaps_on   = !(k >= 150 && k < 250);
            rsp_stalls_on = req_gaps_on;
            if (line_q.size() < fill_goal)
                adding = ($urandom_range(0, 99) < 75);
            else
                adding = ($urandom_range(0, 99) < 25);
            pick = $urandom_range(0, 99);
            if (adding)
                op = (pick < 40) ? OP_ADD_URGENT : OP_ADD_NORMAL;
            else
                op = (pick < 45) ? OP_SERVE : OP_CANCEL;
            tag  = TAG_W'($urandom);
            // cancel mostly hits a queued ticket, otherwise a stale, random or edge one
            pick = $urandom_range(0, 99);
            if (pick < 65 && line_q.size() != 0)
                want = line_q[$urandom_range(0, line_q.size() - 1)].ticket;
            else if (pick < 80)
                want = last_served;
            else if (pick < 90)
                want = TICKET_W'($urandom);
            else
                case ($urandom_range(0, 3))
                    0:       want = '0;
                    1:       want = '1;
                    2:       want = TICKET_W'(NORMAL_LAST);
                    default: want = URGENT_BASE;
                endcase
            send_request(op, tag, want, forecast);
            if (op == OP_SERVE && forecast.status == ST_OK)
                last_served = forecast.ticket;
            if (k == 300)
                wait_for_replies();
        end

        // normal ticket lap: one normal entry waits at the head while add and cancel
        // pairs carry the counter all the way round to its ticket again
        req_gaps_on   = 1'b1;
        rsp_stalls_on = 1'b1;
        while (line_q.size() != 0)
            send_request(OP_SERVE, TAG_W'($urandom), TICKET_W'($urandom), forecast);
        send_request(OP_ADD_NORMAL, TAG_W'($urandom), TICKET_W'($urandom), forecast);
        held = forecast.ticket;
        while ((normal_last % NORMAL_LAST) + 1 != held)
        begin
            send_request(OP_ADD_NORMAL, TAG_W'($urandom), TICKET_W'($urandom), forecast);
            send_request(OP_CANCEL, TAG_W'($urandom), forecast.ticket, forecast);
        end
        // the same ticket is now queued twice; cancel must take the older one
        send_request(OP_ADD_NORMAL, TAG_W'($urandom), TICKET_W'($urandom), forecast);
        send_request(OP_CANCEL, TAG_W'($urandom), held, forecast);
        send_request(OP_SERVE, TAG_W'($urandom), TICKET_W'($urandom), forecast);

        // let the last replies in, then watch a little longer for strays
        wait_for_replies();
        repeat (2 * DEPTH + 8) @(posedge clk);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // response side ready, stalled at random while stalls are on
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !(rsp_stalls_on && $urandom_range(0, 99) < 28);
        end
    end

    // compare each reply taken from the block with the oldest one owed
    always @(posedge clk)
    begin
        reply_t owed;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (replies_due.size() == 0)
            begin
                note_failure("response with no request outstanding");
            end
            else
            begin
                owed = replies_due.pop_front();
                if (rsp_ch.status !== owed.status)
                    note_failure($sformatf("status expected %0d got %0d",
                                           owed.status, rsp_ch.status));
                if (rsp_ch.ticket_out !== owed.ticket)
                    note_failure($sformatf("ticket_out expected %0d got %0d",
                                           owed.ticket, rsp_ch.ticket_out));
                if (rsp_ch.tag_out !== owed.tag)
                    note_failure($sformatf("tag_out expected %h got %h",
                                           owed.tag, rsp_ch.tag_out));
                if (rsp_ch.urgent_waiting !== owed.urgent)
                    note_failure($sformatf("urgent_waiting expected %b got %b",
                                           owed.urgent, rsp_ch.urgent_waiting));
                if (rsp_ch.occupancy !== owed.occupancy)
                    note_failure($sformatf("occupancy expected %0d got %0d",
                                           owed.occupancy, rsp_ch.occupancy));
            end
        end
    end

    // about 560 requests in all, plus gaps and stalls; this bound sits
    // several times above the slowest correct run
    initial
    begin
        #400_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
